FILE: hw/rtl/assert_macros.svh
// assertion macros for the probe reply collector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("label");
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("label");
`else
`define CHK_IMPLY(label, clk, rst, a, b)
`define CHK_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: hw/rtl/prc_pkg.sv
// shared types and constants of the probe reply collector
`default_nettype none
package prc_pkg;
  localparam int SLOTS = 16;
  localparam int NODES = 16;
  localparam logic [1:0] STATUS_MASK = 2'h3;

  typedef enum logic [2:0] {
    M_ACQUIRE = 3'd0, M_RELEASE = 3'd1, M_DISPATCH = 3'd2, M_REPLY = 3'd3,
    M_AGGREGATE = 3'd4, M_TICK = 3'd5, M_NODE_DEAD = 3'd6, M_EXIT = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    K_GRANTED = 4'd0, K_FULL = 4'd1, K_SEND = 4'd2, K_DISPATCHED = 4'd3,
    K_ACCEPTED = 4'd4, K_DROPPED = 4'd5, K_PENDING = 4'd6, K_HOLDER = 4'd7,
    K_WAITER = 4'd8, K_CLEAR = 4'd9, K_RETRY = 4'd10, K_TIMEOUT = 4'd11,
    K_RELEASED = 4'd12, K_DONE = 4'd13, K_INACTIVE = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    R_ACTIVE = 3'd0, R_RETRY = 3'd1, R_BUDGET = 3'd2, R_OWN = 3'd3, R_LIVE = 3'd4
  } reg_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_FAN = 5'b00100,
    S_STAT = 5'b01000, S_FINISH = 5'b10000
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/probe_reply_collector_unit.sv
// probe reply collector: one slot or node per cycle under a small sequencer
// An item is taken at a clock edge where start is high and busy low. Acquire, reply, tick,
// node dead and requester exit then walk the active slots one per cycle, up to 16 slots,
// then give the closing result; acquire and reply stop at the slot they hit. Dispatch
// walks the 16 nodes one per cycle, one send for each live node other than own_node,
// then gives the closing result; an inactive slot ends it at once. Release and aggregate
// go straight to a status step. Each result is on the ports for one cycle, the cycle after
// the step that makes it, and the receiver cannot stall it. Busy falls as the last result
// of an item appears, so the next item can be taken at the edge that ends that result.
`default_nettype none
`include "assert_macros.svh"
module probe_reply_collector_unit import prc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode,
  input  wire logic [3:0]  slot_index,
  input  wire logic [3:0]  node_id,
  input  wire logic [1:0]  probe_status,
  input  wire logic [63:0] reply_id,
  input  wire logic [15:0] requester_id,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             result_valid,
  output logic [3:0]       kind,
  output logic [3:0]       slot_index_res,
  output logic [3:0]       target_node,
  output logic [63:0]      probe_tag,
  output logic             last
);
  logic [4:0]  active_slots;
  logic [15:0] retry_interval;
  logic [7:0]  retry_budget;
  logic [3:0]  own_node;
  logic [15:0] live_node_mask;

  logic        slot_busy [SLOTS];
  logic [63:0] slot_tag [SLOTS];
  logic [15:0] exp_m [SLOTS];
  logic [15:0] rcv_m [SLOTS];
  logic [31:0] pstat [SLOTS];
  logic [7:0]  tally [SLOTS];
  logic [15:0] age [SLOTS];
  logic [15:0] slot_req [SLOTS];
  logic [63:0] next_tag;

  state_t      state;
  mode_t       op;
  logic [3:0]  sidx, node;
  logic [1:0]  stat;
  logic [63:0] pid;
  logic [15:0] req;
  logic [3:0]  cnt;
  logic [4:0]  cap;

  logic [3:0] cur;
  logic       cur_last;
  logic       c_busy, c_inc;
  logic [15:0] age_inc;
  logic [15:0] nbit;
  logic       scan_hit;
  logic       fan_send;

  assign busy = (state != S_IDLE);
  assign cur = (state == S_SCAN) ? cnt : sidx;
  assign cur_last = ({1'b0, cnt} == cap - 5'd1);
  assign c_busy = slot_busy[cur];
  assign c_inc = (exp_m[cur] != rcv_m[cur]);
  assign age_inc = (age[cur] != 16'hFFFF) ? age[cur] + 16'd1 : age[cur];
  assign nbit = 16'd1 << node;
  assign scan_hit = (op == M_ACQUIRE && !c_busy) ||
                    (op == M_REPLY && c_busy && slot_tag[cur] == pid);
  assign fan_send = (cnt != own_node) && live_node_mask[cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= 5'd16;
      retry_interval <= 16'd100;
      retry_budget <= 8'd3;
      own_node <= 4'd0;
      live_node_mask <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        R_ACTIVE: active_slots <= cfg_data[4:0];
        R_RETRY:  retry_interval <= cfg_data;
        R_BUDGET: retry_budget <= cfg_data[7:0];
        R_OWN:    own_node <= cfg_data[3:0];
        R_LIVE:   live_node_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  task automatic put(input kind_t k, input logic [3:0] s, input logic [3:0] t,
                     input logic [63:0] g, input logic l);
    result_valid <= 1'b1;
    kind <= k;
    slot_index_res <= s;
    target_node <= t;
    probe_tag <= g;
    last <= l;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      next_tag <= 64'd1;
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i] <= 1'b0;
        exp_m[i] <= '0;
        rcv_m[i] <= '0;
        pstat[i] <= '0;
        tally[i] <= '0;
        age[i] <= '0;
      end
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= mode_t'(mode);
            sidx <= slot_index;
            node <= node_id;
            stat <= probe_status;
            pid <= reply_id;
            req <= requester_id;
            cnt <= '0;
            cap <= (active_slots == 5'd0) ? 5'd1 :
                   (active_slots > 5'd16) ? 5'd16 : active_slots;
            case (mode_t'(mode))
              M_RELEASE, M_AGGREGATE: state <= S_STAT;
              M_DISPATCH: state <= S_FAN;
              default: state <= S_SCAN;
            endcase
          end
        end
        S_FAN: begin
          if (!c_busy) begin
            put(K_INACTIVE, sidx, 4'd0, 64'd0, 1'b1);
            state <= S_IDLE;
          end else begin
            if (cnt == 4'd0) begin
              rcv_m[sidx] <= rcv_m[sidx] | (16'd1 << own_node);
              pstat[sidx] <= pstat[sidx] | ({30'd0, stat} << {own_node, 1'b0});
              age[sidx] <= '0;
            end
            exp_m[sidx] <= exp_m[sidx] |
                           ((cnt == 4'd0) ? (16'd1 << own_node) : 16'd0) |
                           (fan_send ? (16'd1 << cnt) : 16'd0);
            if (fan_send) begin
              put(K_SEND, sidx, cnt, slot_tag[sidx], 1'b0);
            end
            cnt <= cnt + 4'd1;
            if (cnt == 4'd15) state <= S_FINISH;
          end
        end
        S_STAT: begin
          if (op == M_RELEASE) begin
            put(K_RELEASED, sidx, 4'd0, c_busy ? slot_tag[sidx] : 64'd0, 1'b1);
            slot_busy[sidx] <= 1'b0;
          end else if (!c_busy) begin
            put(K_INACTIVE, sidx, 4'd0, 64'd0, 1'b1);
          end else if (c_inc) begin
            put(K_PENDING, sidx, 4'd0, slot_tag[sidx], 1'b1);
          end else begin
            logic h, w;
            h = 1'b0;
            w = 1'b0;
            for (int k = 0; k < NODES; k++) begin
              if ((pstat[sidx][2*k +: 2] & STATUS_MASK) == 2'd1) h = 1'b1;
              if ((pstat[sidx][2*k +: 2] & STATUS_MASK) == 2'd2) w = 1'b1;
            end
            put(h ? K_HOLDER : (w ? K_WAITER : K_CLEAR), sidx, 4'd0,
                slot_tag[sidx], 1'b1);
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          cnt <= cnt + 4'd1;
          if (scan_hit) state <= S_IDLE;
          else if (cur_last) state <= S_FINISH;
          case (op)
            M_ACQUIRE: begin
              if (!c_busy) begin
                slot_busy[cur] <= 1'b1;
                slot_tag[cur] <= next_tag;
                next_tag <= next_tag + 64'd1;
                slot_req[cur] <= req;
                tally[cur] <= '0;
                age[cur] <= '0;
                exp_m[cur] <= '0;
                rcv_m[cur] <= '0;
                pstat[cur] <= '0;
                put(K_GRANTED, cur, 4'd0, next_tag, 1'b1);
              end
            end
            M_REPLY: begin
              if (c_busy && slot_tag[cur] == pid) begin
                if (!exp_m[cur][node] || rcv_m[cur][node]) begin
                  put(K_DROPPED, cur, 4'd0, slot_tag[cur], 1'b1);
                end else begin
                  rcv_m[cur] <= rcv_m[cur] | nbit;
                  pstat[cur] <= pstat[cur] | ({30'd0, stat} << {node, 1'b0});
                  put(K_ACCEPTED, cur, 4'd0, slot_tag[cur], 1'b1);
                end
              end
            end
            M_TICK: begin
              if (c_busy && c_inc) begin
                age[cur] <= (age_inc >= retry_interval && tally[cur] < retry_budget) ?
                            16'd0 : age_inc;
                if (age_inc >= retry_interval) begin
                  if (tally[cur] >= retry_budget) begin
                    slot_busy[cur] <= 1'b0;
                    put(K_TIMEOUT, cur, 4'd0, slot_tag[cur], 1'b0);
                  end else begin
                    tally[cur] <= tally[cur] + 8'd1;
                    exp_m[cur] <= '0;
                    rcv_m[cur] <= '0;
                    pstat[cur] <= '0;
                    put(K_RETRY, cur, 4'd0, slot_tag[cur], 1'b0);
                  end
                end
              end
            end
            M_NODE_DEAD: begin
              if (c_busy && exp_m[cur][node]) rcv_m[cur] <= rcv_m[cur] | nbit;
            end
            M_EXIT: begin
              if (c_busy && slot_req[cur] == req) begin
                slot_busy[cur] <= 1'b0;
                put(K_RELEASED, cur, 4'd0, slot_tag[cur], 1'b0);
              end
            end
            default: ;
          endcase
        end
        S_FINISH: begin
          case (op)
            M_ACQUIRE: put(K_FULL, 4'd0, 4'd0, 64'd0, 1'b1);
            M_REPLY:   put(K_DROPPED, 4'd0, 4'd0, pid, 1'b1);
            M_DISPATCH: put(K_DISPATCHED, sidx, 4'd0, slot_tag[sidx], 1'b1);
            default:   put(K_DONE, 4'd0, 4'd0, 64'd0, 1'b1);
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPLY(a_last_ends, clk, rst, result_valid && last, state == S_IDLE)
  `CHK_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `CHK_IMPLY(a_idle_quiet, clk, rst, state == S_IDLE && !$past(busy), !result_valid)
endmodule
`default_nettype wire
